>>> src/ale_pkg.sv
// Package for the array list engine: sizes, opcodes, status codes, sequencer states.
// No dependencies.
package ale_pkg;

    localparam int DEPTH      = 256;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int VAL_W      = 40;

    typedef enum logic [3:0] {
        OP_APPEND  = 4'd0,
        OP_INSERT  = 4'd1,
        OP_DELETE  = 4'd2,
        OP_SWAP    = 4'd3,
        OP_GET     = 4'd4,
        OP_LSEARCH = 4'd5,
        OP_BSEARCH = 4'd6,
        OP_MAX     = 4'd7,
        OP_MIN     = 4'd8,
        OP_SUM     = 4'd9,
        OP_REVERSE = 4'd10
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SHUP_RD,     // insert: read entry i-1
        S_SHUP_WR,     // insert: write entry i
        S_SHDN_RD,
        S_SHDN_WR,
        S_PAIR_RDA,    // swap / reverse: read first of pair
        S_PAIR_RDB,
        S_PAIR_WRA,
        S_PAIR_WRB,
        S_SCAN_RD,     // linear search, max, min, sum, get
        S_SCAN_CHK,
        S_BIN_RD,
        S_BIN_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] value;
        logic [7:0]       position;
        logic [8:0]       element_count;
    } result_t;

endpackage

>>> src/ale_if.sv
// Valid/ready channel interfaces for the command and response payloads.
// No dependencies; payload fields are plain logic vectors.
interface ale_cmd_if (input logic clk);
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic [7:0]  index_a;
    logic [7:0]  index_b;
    logic signed [31:0] key;
    modport source (output valid, opcode, index_a, index_b, key, input ready);
    modport sink   (input valid, opcode, index_a, index_b, key, output ready);
endinterface

interface ale_rsp_if (input logic clk);
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [39:0] value;
    logic [7:0]  position;
    logic [8:0]  element_count;
    modport source (output valid, status, value, position, element_count, input ready);
    modport sink   (input valid, status, value, position, element_count, output ready);
endinterface

>>> src/ale_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies beyond its parameters.
module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH_P = 256
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH_P)-1:0] waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH_P)-1:0] raddr,
    output logic [WIDTH-1:0]           rdata
);
    logic [WIDTH-1:0] mem [DEPTH_P];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end
endmodule

>>> src/ale_seq.sv
// Sequencer: walks the element memory at most one access a cycle for each opcode.
// Depends on ale_pkg; drives ale_ram through a mem_req_t bundle.
module ale_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [3:0]                      opcode,
    input  logic [7:0]                      index_a,
    input  logic [7:0]                      index_b,
    input  logic [31:0]                     key,
    input  logic [ale_pkg::DATA_WIDTH-1:0]  rdata,
    output ale_pkg::mem_req_t               mreq,
    output logic                            busy,
    output logic                            done,
    output ale_pkg::result_t                result
);
    import ale_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [3:0]        op_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    // i/j are signed-capable walk pointers (hi can go to -1)
    logic signed [CNT_W:0] i_reg, i_next, j_reg, j_next;
    logic [DATA_WIDTH-1:0] tmp_reg, tmp_next;
    logic [1:0]        status_reg, status_next;
    logic [VAL_W-1:0]  value_reg, value_next;
    logic [7:0]        pos_reg, pos_next;
    logic signed [CNT_W:0] mid;
    logic signed [VAL_W-1:0] rval, kval;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] ia, ib;

    assign n    = count_reg;
    assign ia   = CNT_W'(index_a);
    assign ib   = CNT_W'(index_b);
    assign rval = VAL_W'($signed(rdata));
    assign kval = VAL_W'($signed(key_reg));
    assign mid  = (i_reg + j_reg) >>> 1;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        tmp_next    = tmp_reg;
        status_next = status_reg;
        value_next  = value_reg;
        pos_next    = pos_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = ST_OK;
                    value_next  = '0;
                    pos_next    = '0;
                    state_next  = S_DONE;
                    unique case (opcode)
                        OP_APPEND, OP_INSERT:
                        begin
                            if (n >= CNT_W'(DEPTH))
                                status_next = ST_FULL;
                            else if (opcode == OP_INSERT && ia > n)
                                status_next = ST_RANGE;
                            else
                            begin
                                i_next = (CNT_W+1)'(n);
                                j_next = (opcode == OP_APPEND) ? (CNT_W+1)'(n) : (CNT_W+1)'(ia);
                                state_next = S_SHUP_RD;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (ia >= n)
                                status_next = ST_RANGE;
                            else
                            begin
                                i_next = (CNT_W+1)'(ia);
                                state_next = S_SHDN_RD;
                            end
                        end
                        OP_SWAP:
                        begin
                            if (ia >= n || ib >= n)
                                status_next = ST_RANGE;
                            else
                            begin
                                i_next = (CNT_W+1)'(ia);
                                j_next = (CNT_W+1)'(ib);
                                state_next = S_PAIR_RDA;
                            end
                        end
                        OP_REVERSE:
                        begin
                            i_next = '0;
                            j_next = (CNT_W+1)'(n) - 2'sd1;
                            if (n > CNT_W'(1))
                                state_next = S_PAIR_RDA;
                        end
                        OP_GET:
                        begin
                            if (ia >= n)
                                status_next = ST_RANGE;
                            else
                            begin
                                i_next = (CNT_W+1)'(ia);
                                j_next = (CNT_W+1)'(ia) + 2'sd1;
                                state_next = S_SCAN_RD;
                            end
                        end
                        OP_LSEARCH, OP_MAX, OP_MIN, OP_SUM:
                        begin
                            i_next = '0;
                            j_next = (CNT_W+1)'(n);
                            if (opcode == OP_LSEARCH)
                                status_next = ST_NOTFOUND;
                            if ((opcode == OP_MAX || opcode == OP_MIN) && n == '0)
                                status_next = ST_RANGE;
                            else if (n != '0)
                                state_next = S_SCAN_RD;
                        end
                        OP_BSEARCH:
                        begin
                            status_next = ST_NOTFOUND;
                            i_next = '0;
                            j_next = (CNT_W+1)'(n) - 2'sd1;
                            if (n != '0)
                                state_next = S_BIN_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SHUP_RD:
            begin
                if (i_reg > j_reg)
                    state_next = S_SHUP_WR;
                else
                begin
                    // final slot: drop the key in and grow
                    count_next = n + 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SHUP_WR:
            begin
                i_next = i_reg - 2'sd1;
                state_next = S_SHUP_RD;
            end
            S_SHDN_RD:
            begin
                if (i_reg + 2'sd1 < (CNT_W+1)'(n))
                    state_next = S_SHDN_WR;
                else
                begin
                    count_next = n - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SHDN_WR:
            begin
                i_next = i_reg + 2'sd1;
                state_next = S_SHDN_RD;
            end
            S_PAIR_RDA: state_next = S_PAIR_RDB;
            S_PAIR_RDB:
            begin
                tmp_next = rdata;
                state_next = S_PAIR_WRA;
            end
            S_PAIR_WRA: state_next = S_PAIR_WRB;
            S_PAIR_WRB:
            begin
                if (op_reg == OP_REVERSE && (i_reg + 2'sd1) < (j_reg - 2'sd1))
                begin
                    i_next = i_reg + 2'sd1;
                    j_next = j_reg - 2'sd1;
                    state_next = S_PAIR_RDA;
                end
                else
                    state_next = S_DONE;
            end
            S_SCAN_RD: state_next = S_SCAN_CHK;
            S_SCAN_CHK:
            begin
                state_next = S_SCAN_RD;
                unique case (op_reg)
                    OP_GET: value_next = rval;
                    OP_LSEARCH:
                    begin
                        if (rval == kval)
                        begin
                            status_next = ST_OK;
                            pos_next = i_reg[7:0];
                            state_next = S_DONE;
                        end
                    end
                    OP_MAX:
                    begin
                        if (i_reg == '0 || $signed(rval) > $signed(value_reg))
                            value_next = rval;
                    end
                    OP_MIN:
                    begin
                        if (i_reg == '0 || $signed(rval) < $signed(value_reg))
                            value_next = rval;
                    end
                    default: value_next = value_reg + rval;
                endcase
                i_next = i_reg + 2'sd1;
                if (i_reg + 2'sd1 >= j_reg)
                    state_next = S_DONE;
            end
            S_BIN_RD:
            begin
                tmp_next = DATA_WIDTH'(mid);
                state_next = S_BIN_CHK;
            end
            S_BIN_CHK:
            begin
                state_next = S_BIN_RD;
                if (rval == kval)
                begin
                    status_next = ST_OK;
                    pos_next = tmp_reg[7:0];
                    state_next = S_DONE;
                end
                else if ($signed(rval) > $signed(kval))
                begin
                    j_next = $signed((CNT_W+1)'(tmp_reg)) - 2'sd1;
                    if (i_reg > j_next)
                        state_next = S_DONE;
                end
                else
                begin
                    i_next = $signed((CNT_W+1)'(tmp_reg)) + 2'sd1;
                    if (i_next > j_reg)
                        state_next = S_DONE;
                end
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Memory access per state
    always_comb
    begin
        mreq = '0;
        unique case (state_reg)
            S_SHUP_RD:
            begin
                if (i_reg > j_reg)
                begin
                    mreq.re = 1'b1;
                    mreq.raddr = ADDR_W'(i_reg - 2'sd1);
                end
                else
                begin
                    mreq.we = 1'b1;
                    mreq.waddr = ADDR_W'(j_reg);
                    mreq.wdata = key_reg;
                end
            end
            S_SHUP_WR:
            begin
                mreq.we = 1'b1;
                mreq.waddr = ADDR_W'(i_reg);
                mreq.wdata = rdata;
            end
            S_SHDN_RD:
            begin
                mreq.re = 1'b1;
                mreq.raddr = ADDR_W'(i_reg + 2'sd1);
            end
            S_SHDN_WR:
            begin
                mreq.we = 1'b1;
                mreq.waddr = ADDR_W'(i_reg);
                mreq.wdata = rdata;
            end
            S_PAIR_RDA:
            begin
                mreq.re = 1'b1;
                mreq.raddr = ADDR_W'(i_reg);
            end
            S_PAIR_RDB:
            begin
                mreq.re = 1'b1;
                mreq.raddr = ADDR_W'(j_reg);
            end
            S_PAIR_WRA:
            begin
                mreq.we = 1'b1;
                mreq.waddr = ADDR_W'(i_reg);
                mreq.wdata = rdata;
            end
            S_PAIR_WRB:
            begin
                mreq.we = 1'b1;
                mreq.waddr = ADDR_W'(j_reg);
                mreq.wdata = tmp_reg;
            end
            S_SCAN_RD:
            begin
                mreq.re = 1'b1;
                mreq.raddr = ADDR_W'(i_reg);
            end
            S_BIN_RD:
            begin
                mreq.re = 1'b1;
                mreq.raddr = ADDR_W'(mid);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        busy = (state_reg != S_IDLE);
        done = (state_reg == S_DONE);
        result.status = status_reg;
        result.value = value_reg;
        result.position = pos_reg;
        result.element_count = 9'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg  <= opcode;
            key_reg <= DATA_WIDTH'(key);
        end
        i_reg      <= i_next;
        j_reg      <= j_next;
        tmp_reg    <= tmp_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        pos_reg    <= pos_next;
    end
endmodule

>>> src/array_list_engine.sv
// Top level of the array list engine: command/response channels around the
// sequencer and the element RAM. Depends on ale_pkg, ale_if, ale_seq, ale_ram.
//
// Usage: present an item on cmd (opcode, index_a, index_b, key); one result
// beat per item comes back on rsp (status, value, position, element_count).
// The element store is a 256 x 32 synchronous RAM with registered read data;
// the sequencer does at most one RAM access a cycle. Per item:
//   failed or trivial ops: straight to the result register, no RAM access
//   append/insert: a read and a write per entry shifted up, then the key
//   write; delete: a read and a write per entry shifted down
//   get: one read; swap: two reads, two writes; reverse: two of each per end pair
//   linear search/max/min/sum: a read and a check per element visited
//   binary search: a read and a check per probe, at most 9 probes
// Items are taken one at a time; the next is accepted once the previous
// result has left the output register or leaves it in the same cycle. A
// stalled receiver holds the result and blocks the next item from being
// accepted. Reset empties the store (count 0); entries are never cleared
// because none is read before it is written.
module array_list_engine (
    input  logic      clk,
    input  logic      rst_n,
    ale_cmd_if.sink   cmd,
    ale_rsp_if.source rsp
);
    import ale_pkg::*;

    mem_req_t mreq;
    result_t  result;
    logic [DATA_WIDTH-1:0] rdata;
    logic busy, done, start, rsp_valid_reg;
    result_t rsp_reg;

    assign cmd.ready = !busy && !(rsp_valid_reg && !rsp.ready);
    assign start     = cmd.valid && cmd.ready;

    ale_seq u_seq (
        .clk(clk), .rst_n(rst_n), .start(start),
        .opcode(cmd.opcode), .index_a(cmd.index_a), .index_b(cmd.index_b),
        .key(cmd.key), .rdata(rdata), .mreq(mreq), .busy(busy), .done(done),
        .result(result)
    );

    ale_ram #(.WIDTH(DATA_WIDTH), .DEPTH_P(DEPTH)) u_ram (
        .clk(clk), .we(mreq.we), .waddr(mreq.waddr), .wdata(mreq.wdata),
        .re(mreq.re), .raddr(mreq.raddr), .rdata(rdata)
    );

    // Hold the result beat until taken; done only fires when it is free
    // because a new item is started only with the register free or draining.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (done)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            rsp_reg <= result;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_reg.status;
    assign rsp.value         = rsp_reg.value;
    assign rsp.position      = rsp_reg.position;
    assign rsp.element_count = rsp_reg.element_count;
endmodule

>>> src/ale_checker.sv
// Port-level checker for array_list_engine, bound to the top level.
// Depends on ale_pkg status codes.
module ale_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  rsp_status,
    input logic [8:0]  rsp_element_count
);
    import ale_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
        else $error("result beat dropped while stalled");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_element_count <= 9'(DEPTH))
        else $error("element count above depth");

    a_no_accept_during_stall: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !cmd_ready)
        else $error("item accepted while result stalled");

    a_full_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_FULL |-> rsp_element_count == 9'(DEPTH))
        else $error("full status with free space");
endmodule

bind array_list_engine ale_checker u_ale_checker (
    .clk(clk), .rst_n(rst_n),
    .cmd_ready(cmd.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
    .rsp_element_count(rsp.element_count)
);
